>>> src/smi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smi_pkg
// Shared types, constants and layout helpers of the spiking MLP engine.
// ----------------------------------------------------------------------------
package smi_pkg;

   localparam int DATA_W  = 24;
   localparam int LEAK_W  = 16;
   localparam int CNT_W   = 8;
   localparam int STEP_W  = 8;
   localparam int LA_W    = 16;   // layout address width, covers every parameter value
   localparam int GRP_W   = 7;
   localparam int K_W     = 6;
   localparam int N_W     = 8;
   localparam int CSR_W   = 2;
   localparam int WIDX_W  = 12;

   localparam int HIDDEN_NEURONS_DEF = 32;
   localparam int OUTPUT_NEURONS_DEF = 4;
   localparam int WEIGHT_WORDS_DEF   = 2340;
   localparam int LANES_DEF          = 4;

   localparam logic [DATA_W-1:0] THRESHOLD_RST = 24'd26214;
   localparam logic [LEAK_W-1:0] LEAK_RST      = 16'd62259;
   localparam logic [STEP_W-1:0] STEPS_RST     = 8'd130;

   localparam logic [CSR_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_W-1:0] CSR_LEAK      = 2'd1;
   localparam logic [CSR_W-1:0] CSR_STEPS     = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic [1:0] LAYER_IN  = 2'd0;
   localparam logic [1:0] LAYER_OUT = 2'd3;

   localparam logic signed [DATA_W-1:0] POT_MAX = 24'sh7FFFFF;
   localparam logic signed [DATA_W-1:0] POT_MIN = -24'sh800000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_MUL,
      ST_DEC,
      ST_ACC,
      ST_BIAS,
      ST_WB,
      ST_COUNT,
      ST_REPORT
   } ctrl_state_type;

   typedef struct packed {
      ctrl_state_type    phase;
      logic [1:0]        layer;
      logic [GRP_W-1:0]  grp;
      logic [K_W-1:0]    k;
      logic              last;
      logic [LA_W-1:0]   grp_base;
      logic [LA_W-1:0]   bias_base;
   } lane_ctl_type;

   typedef struct packed {
      logic hit;
      logic rsp_free;
   } mrg_status_type;

   function automatic logic [LA_W-1:0] layer_wbase(input logic [1:0] layer,
                                                   input int h);
      logic [LA_W-1:0] r;
      unique case (layer)
         2'd0:    r = '0;
         2'd1:    r = LA_W'(3 * h);
         2'd2:    r = LA_W'(4 * h + h * h);
         default: r = LA_W'(5 * h + 2 * h * h);
      endcase
      return r;
   endfunction

   function automatic logic [LA_W-1:0] layer_bbase(input logic [1:0] layer,
                                                   input int h, input int o);
      logic [LA_W-1:0] r;
      unique case (layer)
         2'd0:    r = LA_W'(2 * h);
         2'd1:    r = LA_W'(3 * h + h * h);
         2'd2:    r = LA_W'(4 * h + 2 * h * h);
         default: r = LA_W'(5 * h + 2 * h * h + o * h);
      endcase
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_add(
      input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      logic signed [DATA_W-1:0] r;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         r = s[DATA_W] ? POT_MIN : POT_MAX;
      end else begin
         r = s[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> src/smi_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smi_lane
// One neuron unit: own weight copy, own potentials, decay multiply and
// saturating accumulate, one weight word per cycle.
// ----------------------------------------------------------------------------
module smi_lane
   import smi_pkg::*;
#(
   parameter int LANE_ID        = 0,
   parameter int LANES          = LANES_DEF,
   parameter int HIDDEN_NEURONS = HIDDEN_NEURONS_DEF,
   parameter int OUTPUT_NEURONS = OUTPUT_NEURONS_DEF,
   parameter int WEIGHT_WORDS   = WEIGHT_WORDS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lane_ctl_type               ctl,
   input  wire logic                       gate,
   input  wire logic                       prev_spike,
   input  wire logic signed [DATA_W-1:0]   threshold,
   input  wire logic [LEAK_W-1:0]          leak,
   input  wire logic                       wr_en,
   input  wire logic [WIDX_W-1:0]          wr_addr,
   input  wire logic signed [DATA_W-1:0]   wr_data,
   output logic                            spike
);

   localparam int GH     = (HIDDEN_NEURONS + LANES - 1) / LANES;
   localparam int GO     = (OUTPUT_NEURONS + LANES - 1) / LANES;
   localparam int GMAX   = (GH > GO) ? GH : GO;
   localparam int PDEPTH = 4 * GMAX;
   localparam int PAW    = $clog2(PDEPTH);
   localparam int WAW    = $clog2(WEIGHT_WORDS);
   localparam logic [LA_W-1:0] OFF_IN = LA_W'(LANE_ID * 2);
   localparam logic [LA_W-1:0] OFF_H  = LA_W'(LANE_ID * HIDDEN_NEURONS);
   localparam logic [LA_W-1:0] LID    = LA_W'(LANE_ID);
   localparam logic [LA_W-1:0] WWORDS = LA_W'(WEIGHT_WORDS);
   localparam int PROD_W = DATA_W + LEAK_W + 1;

   logic signed [DATA_W-1:0] wmem [WEIGHT_WORDS];
   logic signed [DATA_W-1:0] pmem [PDEPTH];
   logic [PDEPTH-1:0]        pvld_ff;

   logic [LA_W-1:0]          addr_ff, addr_in;
   logic [LA_W-1:0]          rd_addr, wr_addr_x;
   logic [PAW-1:0]           pot_addr;
   logic signed [DATA_W-1:0] wq_ff, pq_ff;
   logic                     wok_ff, pv_ff;
   logic signed [DATA_W-1:0] wval, pval;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] acc_ff, acc_in;

   assign wr_addr_x = LA_W'(wr_addr);
   assign pot_addr  = PAW'(int'(ctl.layer) * GMAX + int'(ctl.grp));
   assign rd_addr   = (ctl.phase == ST_ACC && ctl.last) ? ctl.bias_base + LID : addr_ff;
   assign wval      = wok_ff ? wq_ff : '0;
   assign pval      = pv_ff ? pq_ff : '0;
   assign spike     = acc_ff > threshold;

   always_ff @(posedge clock) begin
      if (wr_en && wr_addr_x < WWORDS) begin
         wmem[wr_addr_x[WAW-1:0]] <= wr_data;
      end
      wq_ff  <= wmem[rd_addr[WAW-1:0]];
      wok_ff <= rd_addr < WWORDS;
   end

   always_ff @(posedge clock) begin
      if (ctl.phase == ST_WB) begin
         pmem[pot_addr] <= acc_ff;
      end
      pq_ff <= pmem[pot_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= '0;
      end else if (ctl.phase == ST_WB) begin
         pvld_ff[pot_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pv_ff   <= pvld_ff[pot_addr];
      prod_ff <= pval * $signed({1'b0, leak});
      addr_ff <= addr_in;
      acc_ff  <= acc_in;
   end

   always_comb begin
      addr_in = addr_ff;
      acc_in  = acc_ff;
      unique case (ctl.phase)
         ST_START: begin
            addr_in = ctl.grp_base + ((ctl.layer == LAYER_IN) ? OFF_IN : OFF_H);
         end
         ST_DEC: begin
            addr_in = addr_ff + 1'b1;
            acc_in  = prev_spike ? '0 : prod_ff[LEAK_W +: DATA_W];
         end
         ST_ACC: begin
            addr_in = addr_ff + 1'b1;
            if (gate) begin
               acc_in = sat_add(acc_ff, wval);
            end
         end
         ST_BIAS: begin
            acc_in = sat_add(acc_ff, wval);
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

>>> src/smi_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smi_merge
// Collects lane spikes into the layer spike vectors, keeps the output spike
// counts and step number, and holds the result word.
// ----------------------------------------------------------------------------
module smi_merge
   import smi_pkg::*;
#(
   parameter int LANES          = LANES_DEF,
   parameter int HIDDEN_NEURONS = HIDDEN_NEURONS_DEF,
   parameter int OUTPUT_NEURONS = OUTPUT_NEURONS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lane_ctl_type         ctl,
   input  wire logic                 step_take,
   input  wire logic                 sample_a,
   input  wire logic                 sample_b,
   input  wire logic [LANES-1:0]     lane_spike,
   input  wire logic [STEP_W-1:0]    steps_per,
   output logic                      gate,
   output logic [LANES-1:0]          prev_spike,
   output mrg_status_type            status,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_class_index,
   output logic                      rsp_any_spike,
   output logic [CNT_W-1:0]          rsp_count_zero,
   output logic [CNT_W-1:0]          rsp_count_one,
   output logic [CNT_W-1:0]          rsp_count_two,
   output logic [CNT_W-1:0]          rsp_count_three
);

   localparam int HW = $clog2(HIDDEN_NEURONS);
   localparam int OW = (OUTPUT_NEURONS > 1) ? $clog2(OUTPUT_NEURONS) : 1;
   localparam logic [N_W-1:0] H_N = N_W'(HIDDEN_NEURONS);
   localparam logic [N_W-1:0] O_N = N_W'(OUTPUT_NEURONS);

   logic [HIDDEN_NEURONS-1:0] spk_h_ff [3];
   logic [OUTPUT_NEURONS-1:0] spk_o_ff;
   logic                      in_a_ff, in_b_ff;
   logic [CNT_W-1:0]          cnt_ff [OUTPUT_NEURONS];
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      hit_ff;
   logic                      rsp_valid_ff;
   logic [1:0]                cls_ff;
   logic                      any_ff;
   logic [CNT_W-1:0]          rcnt_ff [4];
   logic [CNT_W-1:0]          cnt_view [4];
   logic [N_W-1:0]            nidx [LANES];
   logic [2:0]                best;
   logic [CNT_W-1:0]          maxc;
   logic                      found;
   logic                      load_rsp;
   logic [1:0]                lower;

   for (genvar l = 0; l < LANES; l++) begin : g_idx
      assign nidx[l] = N_W'(int'(ctl.grp) * LANES + l);
   end

   for (genvar c = 0; c < 4; c++) begin : g_view
      if (c < OUTPUT_NEURONS) begin : g_has
         assign cnt_view[c] = cnt_ff[c];
      end else begin : g_none
         assign cnt_view[c] = '0;
      end
   end

   assign lower = ctl.layer - 1'b1;

   always_comb begin
      if (ctl.layer == LAYER_IN) begin
         gate = ctl.k[0] ? in_b_ff : in_a_ff;
      end else begin
         gate = spk_h_ff[lower][ctl.k[HW-1:0]];
      end
      for (int l = 0; l < LANES; l++) begin
         prev_spike[l] = 1'b0;
         if (ctl.layer == LAYER_OUT) begin
            if (nidx[l] < O_N) prev_spike[l] = spk_o_ff[nidx[l][OW-1:0]];
         end else begin
            if (nidx[l] < H_N) prev_spike[l] = spk_h_ff[ctl.layer][nidx[l][HW-1:0]];
         end
      end
   end

   always_comb begin
      best  = '0;
      maxc  = '0;
      found = 1'b0;
      for (int i = 0; i < OUTPUT_NEURONS; i++) begin
         if (cnt_ff[i] > maxc) begin
            maxc  = cnt_ff[i];
            best  = 3'(i);
            found = 1'b1;
         end
      end
   end

   assign step_in         = step_ff + 1'b1;
   assign status.hit      = hit_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign load_rsp        = ctl.phase == ST_REPORT && hit_ff && status.rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 3; j++) spk_h_ff[j] <= '0;
         spk_o_ff <= '0;
         for (int i = 0; i < OUTPUT_NEURONS; i++) cnt_ff[i] <= '0;
         step_ff      <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.phase == ST_WB) begin
            for (int l = 0; l < LANES; l++) begin
               if (ctl.layer == LAYER_OUT) begin
                  if (nidx[l] < O_N) spk_o_ff[nidx[l][OW-1:0]] <= lane_spike[l];
               end else begin
                  if (nidx[l] < H_N) spk_h_ff[ctl.layer][nidx[l][HW-1:0]] <= lane_spike[l];
               end
            end
         end
         if (ctl.phase == ST_COUNT) begin
            for (int i = 0; i < OUTPUT_NEURONS; i++) begin
               cnt_ff[i] <= cnt_ff[i] + CNT_W'(spk_o_ff[i]);
            end
            if (step_in == steps_per) begin
               step_ff <= '0;
               hit_ff  <= 1'b1;
            end else begin
               step_ff <= step_in;
               hit_ff  <= 1'b0;
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_take) begin
         in_a_ff <= sample_a;
         in_b_ff <= sample_b;
      end
      if (load_rsp) begin
         cls_ff <= best[1:0];
         any_ff <= found;
         for (int c = 0; c < 4; c++) rcnt_ff[c] <= cnt_view[c];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_index = cls_ff;
   assign rsp_any_spike   = any_ff;
   assign rsp_count_zero  = rcnt_ff[0];
   assign rsp_count_one   = rcnt_ff[1];
   assign rsp_count_two   = rcnt_ff[2];
   assign rsp_count_three = rcnt_ff[3];

endmodule
`default_nettype wire

>>> src/smi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smi_ctrl
// Sequencer: walks layers and neuron groups, steps the fan-in counter that
// all lanes share, and closes each time step.
// ----------------------------------------------------------------------------
module smi_ctrl
   import smi_pkg::*;
#(
   parameter int LANES          = LANES_DEF,
   parameter int HIDDEN_NEURONS = HIDDEN_NEURONS_DEF,
   parameter int OUTPUT_NEURONS = OUTPUT_NEURONS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_cmd,
   output logic                 req_ready,
   input  wire mrg_status_type  status,
   output lane_ctl_type         ctl
);

   localparam logic [LA_W-1:0] STRIDE_IN = LA_W'(LANES * 2);
   localparam logic [LA_W-1:0] STRIDE_H  = LA_W'(LANES * HIDDEN_NEURONS);
   localparam logic [K_W-1:0]  KLAST_IN  = K_W'(1);
   localparam logic [K_W-1:0]  KLAST_H   = K_W'(HIDDEN_NEURONS - 1);

   ctrl_state_type   state_ff, state_in;
   logic [1:0]       layer_ff, layer_in;
   logic [GRP_W-1:0] grp_ff, grp_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [LA_W-1:0]  gbase_ff, gbase_in;
   logic [LA_W-1:0]  bbase_ff, bbase_in;
   logic             last, grp_last;
   int               nout;

   assign last     = k_ff == ((layer_ff == LAYER_IN) ? KLAST_IN : KLAST_H);
   assign nout     = (layer_ff == LAYER_OUT) ? OUTPUT_NEURONS : HIDDEN_NEURONS;
   assign grp_last = int'(grp_ff) * LANES + LANES >= nout;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         layer_ff <= '0;
         grp_ff   <= '0;
         k_ff     <= '0;
         gbase_ff <= '0;
         bbase_ff <= '0;
      end else begin
         state_ff <= state_in;
         layer_ff <= layer_in;
         grp_ff   <= grp_in;
         k_ff     <= k_in;
         gbase_ff <= gbase_in;
         bbase_ff <= bbase_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      layer_in  = layer_ff;
      grp_in    = grp_ff;
      k_in      = k_ff;
      gbase_in  = gbase_ff;
      bbase_in  = bbase_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_cmd == CMD_STEP) begin
               state_in = ST_START;
               layer_in = LAYER_IN;
               grp_in   = '0;
               gbase_in = layer_wbase(LAYER_IN, HIDDEN_NEURONS);
               bbase_in = layer_bbase(LAYER_IN, HIDDEN_NEURONS, OUTPUT_NEURONS);
            end
         end
         ST_START: state_in = ST_MUL;
         ST_MUL:   state_in = ST_DEC;
         ST_DEC: begin
            state_in = ST_ACC;
            k_in     = '0;
         end
         ST_ACC: begin
            k_in = k_ff + 1'b1;
            if (last) state_in = ST_BIAS;
         end
         ST_BIAS: state_in = ST_WB;
         ST_WB: begin
            if (!grp_last) begin
               state_in = ST_START;
               grp_in   = grp_ff + 1'b1;
               gbase_in = gbase_ff + ((layer_ff == LAYER_IN) ? STRIDE_IN : STRIDE_H);
               bbase_in = bbase_ff + LA_W'(LANES);
            end else if (layer_ff == LAYER_OUT) begin
               state_in = ST_COUNT;
            end else begin
               state_in = ST_START;
               layer_in = layer_ff + 1'b1;
               grp_in   = '0;
               gbase_in = layer_wbase(layer_ff + 1'b1, HIDDEN_NEURONS);
               bbase_in = layer_bbase(layer_ff + 1'b1, HIDDEN_NEURONS, OUTPUT_NEURONS);
            end
         end
         ST_COUNT: state_in = ST_REPORT;
         ST_REPORT: begin
            if (!status.hit || status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign ctl.phase     = state_ff;
   assign ctl.layer     = layer_ff;
   assign ctl.grp       = grp_ff;
   assign ctl.k         = k_ff;
   assign ctl.last      = last;
   assign ctl.grp_base  = gbase_ff;
   assign ctl.bias_base = bbase_ff;

   a_count_then_report: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COUNT |=> state_ff == ST_REPORT)
      else $error("count not followed by report");

   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_STEP |=>
         state_ff == ST_START && layer_ff == LAYER_IN && grp_ff == '0)
      else $error("step word did not start at first group");

   a_acc_walks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC && !last |=>
         state_ff == ST_ACC && k_ff == $past(k_ff) + 1'b1)
      else $error("fan-in walk broken");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");

endmodule
`default_nettype wire

>>> src/spiking_mlp_inference_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spiking_mlp_inference_top
// Leaky integrate-and-fire network 2-H-H-H-O, Q8.16, with LANES neuron
// lanes that each hold a copy of the weight memory.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_ready  cmd, weight index/value, samples
//   rsp      out        rsp_valid/rsp_ready  class, any_spike, four counts
//   csr      in         csr_wr_en            index, data (no read-back)
//
// A weight load leaves the block idle and ready for the next word. A time step
// walks every layer and neuron group, paced by one weight read per lane per
// cycle.
// Reset clears potentials (per-entry valid bits), spikes, counts, step number.
// A pending result waits in the output register; the block goes on accepting
// words and only stalls at the end of a step whose result cannot be loaded.
// ----------------------------------------------------------------------------
module spiking_mlp_inference_top
   import smi_pkg::*;
#(
   parameter int LANES          = LANES_DEF,
   parameter int HIDDEN_NEURONS = HIDDEN_NEURONS_DEF,
   parameter int OUTPUT_NEURONS = OUTPUT_NEURONS_DEF,
   parameter int WEIGHT_WORDS   = WEIGHT_WORDS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_cmd,
   input  wire logic [WIDX_W-1:0]        req_weight_index,
   input  wire logic signed [DATA_W-1:0] req_weight_value,
   input  wire logic                     req_sample_a,
   input  wire logic                     req_sample_b,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_class_index,
   output logic                          rsp_any_spike,
   output logic [CNT_W-1:0]              rsp_count_zero,
   output logic [CNT_W-1:0]              rsp_count_one,
   output logic [CNT_W-1:0]              rsp_count_two,
   output logic [CNT_W-1:0]              rsp_count_three,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_W-1:0]         csr_index,
   input  wire logic [DATA_W-1:0]        csr_wdata
);

   logic signed [DATA_W-1:0] thr_ff;
   logic [LEAK_W-1:0]        leak_ff;
   logic [STEP_W-1:0]        steps_ff;
   lane_ctl_type             ctl;
   mrg_status_type           status;
   logic                     gate;
   logic [LANES-1:0]         prev_spike, lane_spike;
   logic                     take, wr_en, step_take;

   assign take      = req_valid && req_ready;
   assign wr_en     = take && req_cmd == CMD_LOAD;
   assign step_take = take && req_cmd == CMD_STEP;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THRESHOLD_RST;
         leak_ff  <= LEAK_RST;
         steps_ff <= STEPS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_THRESHOLD: thr_ff   <= csr_wdata;
            CSR_LEAK:      leak_ff  <= csr_wdata[LEAK_W-1:0];
            CSR_STEPS:     steps_ff <= csr_wdata[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   smi_ctrl #(
      .LANES(LANES), .HIDDEN_NEURONS(HIDDEN_NEURONS), .OUTPUT_NEURONS(OUTPUT_NEURONS)
   ) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_cmd(req_cmd),
      .req_ready(req_ready), .status(status), .ctl(ctl)
   );

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      smi_lane #(
         .LANE_ID(l), .LANES(LANES), .HIDDEN_NEURONS(HIDDEN_NEURONS),
         .OUTPUT_NEURONS(OUTPUT_NEURONS), .WEIGHT_WORDS(WEIGHT_WORDS)
      ) u_lane (
         .clock(clock), .reset(reset), .ctl(ctl), .gate(gate),
         .prev_spike(prev_spike[l]), .threshold(thr_ff), .leak(leak_ff),
         .wr_en(wr_en), .wr_addr(req_weight_index), .wr_data(req_weight_value),
         .spike(lane_spike[l])
      );
   end

   smi_merge #(
      .LANES(LANES), .HIDDEN_NEURONS(HIDDEN_NEURONS), .OUTPUT_NEURONS(OUTPUT_NEURONS)
   ) u_merge (
      .clock(clock), .reset(reset), .ctl(ctl), .step_take(step_take),
      .sample_a(req_sample_a), .sample_b(req_sample_b), .lane_spike(lane_spike),
      .steps_per(steps_ff), .gate(gate), .prev_spike(prev_spike), .status(status),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_class_index(rsp_class_index), .rsp_any_spike(rsp_any_spike),
      .rsp_count_zero(rsp_count_zero), .rsp_count_one(rsp_count_one),
      .rsp_count_two(rsp_count_two), .rsp_count_three(rsp_count_three)
   );

endmodule
`default_nettype wire
